### rtl/tbgc_pkg.sv
`default_nettype none
package tbgc_pkg;

  // Fixed field widths
  localparam int LUX_W    = 24;
  localparam int GAIN_W   = 26;
  localparam int TIMER_W  = 32;
  localparam int ORDER_W  = 64;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 64;

  localparam logic [4:0]  MAX_NODES  = 5'd16;
  localparam logic [4:0]  ACK_MAX    = 5'd31;
  localparam logic [11:0] DUTY_LOW   = 12'd819;
  localparam logic [11:0] DUTY_HIGH  = 12'd3276;
  localparam logic [11:0] DUTY_OFF   = 12'd0;
  localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

  // Divide by three: floor(a/3) = (a * DIV3_MUL) >> DIV3_SHIFT for a < 2^DIV_IN_W
  localparam int DIV_IN_W   = 27;
  localparam int DIV3_SHIFT = 29;
  localparam logic [27:0] DIV3_MUL = 28'd178956971;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OWN_ID        = 3'd0,
    REG_NODE_COUNT    = 3'd1,
    REG_NODE_ORDER    = 3'd2,
    REG_MEASURE_TICKS = 3'd3,
    REG_RESEND_TICKS  = 3'd4
  } reg_idx_t;

  // Bus message codes
  typedef enum logic [2:0] {
    MSG_REQUEST  = 3'd0,
    MSG_ACK      = 3'd1,
    MSG_LOW      = 3'd2,
    MSG_HIGH     = 3'd3,
    MSG_DONE     = 3'd4,
    MSG_ALL_DONE = 3'd5
  } msg_t;

  // Result kinds
  typedef enum logic [1:0] {
    ACT_TX   = 2'd0,
    ACT_DUTY = 2'd1,
    ACT_GAIN = 2'd2
  } act_t;

  typedef struct packed {
    logic [3:0]         own_node_id;
    logic [4:0]         node_count;
    logic [ORDER_W-1:0] node_order;
    logic [TIMER_W-1:0] measure_ticks;
    logic [TIMER_W-1:0] resend_ticks;
  } cfg_t;

  typedef struct packed {
    logic [LUX_W-1:0] lux_sample;
    logic [7:0]       rx_data;
    logic [3:0]       rx_sender;
    logic [3:0]       rx_type;
    logic             mode;
  } item_t;

  // One result, action in the low bits
  typedef struct packed {
    logic                     all_done;
    logic signed [GAIN_W-1:0] offset_value;
    logic signed [GAIN_W-1:0] gain_value;
    logic [3:0]               gain_slot;
    logic [11:0]              duty;
    logic                     tx_length;
    logic [3:0]               tx_data;
    msg_t                     tx_type;
    act_t                     action;
  } res_t;

endpackage
`default_nettype wire

### rtl/tbgc_gain.sv
`default_nettype none
module tbgc_gain import tbgc_pkg::*; #(
  parameter int RW = 24
) (
  input  wire logic                     clk,
  input  wire logic [RW-1:0]            low_reading,
  input  wire logic [RW-1:0]            high_reading,
  output logic signed [GAIN_W-1:0]      gain_value
);

  localparam int PROD_W = DIV_IN_W + 28;

  logic signed [RW:0]     diff;
  logic [RW-1:0]          mag;
  logic                   neg1;
  logic [DIV_IN_W-1:0]    mag5;
  logic [PROD_W-1:0]      prod;
  logic [GAIN_W-1:0]      quot;

  // Stage 1: |high - low| * 5
  assign diff = $signed({1'b0, high_reading}) - $signed({1'b0, low_reading});
  assign mag  = diff[RW] ? RW'(-diff) : diff[RW-1:0];

  always_ff @(posedge clk) begin
    neg1 <= diff[RW];
    mag5 <= DIV_IN_W'(mag) + (DIV_IN_W'(mag) << 2);
  end

  // Stage 2: divide by three through the reciprocal, restore sign
  assign prod = PROD_W'(mag5) * PROD_W'(DIV3_MUL);
  assign quot = prod[DIV3_SHIFT+GAIN_W-1:DIV3_SHIFT];

  always_ff @(posedge clk) begin
    gain_value <= neg1 ? -$signed(quot) : $signed(quot);
  end

endmodule
`default_nettype wire

### rtl/tbgc_core.sv
`default_nettype none
module tbgc_core import tbgc_pkg::*; #(
  parameter int RW = 24
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     commit,
  input  wire item_t                    item,
  input  wire cfg_t                     cfg,
  input  wire logic signed [GAIN_W-1:0] gain_value,
  output res_t                          res [3],
  output logic [1:0]                    res_n,
  output logic [RW-1:0]                 low_reading,
  output logic [RW-1:0]                 high_reading,
  output logic                          reading_wr
);

  typedef enum logic [6:0] {
    PH_IDLE      = 7'b0000001,
    PH_WAIT_ACK  = 7'b0000010,
    PH_FIRST     = 7'b0000100,
    PH_WAIT_HIGH = 7'b0001000,
    PH_SECOND    = 7'b0010000,
    PH_WAIT_DONE = 7'b0100000,
    PH_FINISH    = 7'b1000000
  } phase_t;

  phase_t             phase, phase_next;
  logic [4:0]         turn_index, turn_index_next;
  logic [4:0]         ack_count, ack_count_next;
  logic [RW-1:0]      low_next, high_next;
  logic [TIMER_W-1:0] measure_timer, measure_timer_next;
  logic [TIMER_W-1:0] resend_timer, resend_timer_next;
  logic               complete_flag, complete_flag_next;

  logic [4:0]         n_eff;
  logic [4:0]         need;
  logic [3:0]         cur_id;
  logic [RW-1:0]      lux;
  logic signed [GAIN_W-1:0] offs;

  function automatic res_t mk_res(act_t a, msg_t t, logic [3:0] d, logic len,
                                  logic [11:0] dt, logic [3:0] slot,
                                  logic signed [GAIN_W-1:0] g,
                                  logic signed [GAIN_W-1:0] o, logic flag);
    res_t r;
    r.action       = a;
    r.tx_type      = t;
    r.tx_data      = d;
    r.tx_length    = len;
    r.duty         = dt;
    r.gain_slot    = slot;
    r.gain_value   = g;
    r.offset_value = o;
    r.all_done     = flag;
    return r;
  endfunction

  function automatic logic [TIMER_W-1:0] sat_inc(logic [TIMER_W-1:0] t);
    return (t == TIMER_MAX) ? t : t + TIMER_W'(1);
  endfunction

  // Node count clamped to 1..MAX_NODES
  assign n_eff  = (cfg.node_count == 5'd0) ? 5'd1 :
                  (cfg.node_count > MAX_NODES) ? MAX_NODES : cfg.node_count;
  assign need   = n_eff - 5'd1;
  assign cur_id = cfg.node_order[{turn_index[3:0], 2'b00} +: 4];
  assign lux    = item.lux_sample[RW-1:0];
  assign offs   = $signed(GAIN_W'(high_reading)) - gain_value;

  // Next state and results of the held item
  always_comb begin
    phase_next         = phase;
    turn_index_next    = turn_index;
    ack_count_next     = ack_count;
    low_next           = low_reading;
    high_next          = high_reading;
    measure_timer_next = measure_timer;
    resend_timer_next  = resend_timer;
    complete_flag_next = complete_flag;
    reading_wr         = 1'b0;
    res_n              = 2'd0;
    for (int i = 0; i < 3; i++) begin
      res[i] = '0;
    end

    if (item.mode) begin
      // Received frame
      case (item.rx_type)
        {1'b0, MSG_REQUEST}: begin
          res[res_n] = mk_res(ACT_TX, MSG_ACK, item.rx_sender, 1'b1, DUTY_OFF, 4'd0,
                              '0, '0, complete_flag_next);
          res_n = res_n + 2'd1;
        end
        {1'b0, MSG_ACK}: begin
          if (item.rx_data == {4'd0, cfg.own_node_id} && ack_count < ACK_MAX) begin
            ack_count_next = ack_count + 5'd1;
          end
        end
        {1'b0, MSG_LOW}: begin
          low_next   = lux;
          reading_wr = 1'b1;
          res[res_n] = mk_res(ACT_TX, MSG_ACK, item.rx_sender, 1'b1, DUTY_OFF, 4'd0,
                              '0, '0, complete_flag_next);
          res_n = res_n + 2'd1;
        end
        {1'b0, MSG_HIGH}: begin
          high_next  = lux;
          reading_wr = 1'b1;
          res[res_n] = mk_res(ACT_TX, MSG_ACK, item.rx_sender, 1'b1, DUTY_OFF, 4'd0,
                              '0, '0, complete_flag_next);
          res_n = res_n + 2'd1;
        end
        {1'b0, MSG_DONE}: begin
          low_next    = '0;
          high_next   = '0;
          reading_wr  = 1'b1;
          phase_next  = PH_IDLE;
          if (turn_index < n_eff) begin
            turn_index_next = turn_index + 5'd1;
          end
          if (turn_index_next >= n_eff) begin
            complete_flag_next = 1'b1;
          end
          res[res_n] = mk_res(ACT_GAIN, MSG_REQUEST, 4'd0, 1'b0, DUTY_OFF,
                              turn_index[3:0], gain_value, '0, complete_flag_next);
          res_n = res_n + 2'd1;
          if (turn_index_next >= n_eff) begin
            res[res_n] = mk_res(ACT_TX, MSG_ALL_DONE, 4'd0, 1'b0, DUTY_OFF, 4'd0,
                                '0, '0, complete_flag_next);
            res_n = res_n + 2'd1;
          end
        end
        {1'b0, MSG_ALL_DONE}: begin
          complete_flag_next = 1'b1;
        end
        default: begin
        end
      endcase
    end else begin
      // Millisecond tick runs the sequencer
      case (phase)
        PH_IDLE: begin
          if (turn_index < n_eff && cur_id == cfg.own_node_id) begin
            res[res_n] = mk_res(ACT_TX, MSG_REQUEST, 4'd0, 1'b0, DUTY_OFF, 4'd0,
                                '0, '0, complete_flag_next);
            res_n = res_n + 2'd1;
            ack_count_next    = 5'd0;
            resend_timer_next = '0;
            phase_next        = PH_WAIT_ACK;
          end
        end
        PH_WAIT_ACK: begin
          resend_timer_next = sat_inc(resend_timer);
          if (resend_timer_next >= cfg.resend_ticks) begin
            res[res_n] = mk_res(ACT_TX, MSG_REQUEST, 4'd0, 1'b0, DUTY_OFF, 4'd0,
                                '0, '0, complete_flag_next);
            res_n = res_n + 2'd1;
            ack_count_next    = 5'd0;
            resend_timer_next = '0;
          end
          if (ack_count_next == need) begin
            res[res_n] = mk_res(ACT_DUTY, MSG_REQUEST, 4'd0, 1'b0, DUTY_LOW, 4'd0,
                                '0, '0, complete_flag_next);
            res_n = res_n + 2'd1;
            measure_timer_next = '0;
            ack_count_next     = 5'd0;
            phase_next         = PH_FIRST;
          end
        end
        PH_FIRST: begin
          measure_timer_next = sat_inc(measure_timer);
          if (measure_timer_next >= cfg.measure_ticks) begin
            low_next   = lux;
            reading_wr = 1'b1;
            res[res_n] = mk_res(ACT_TX, MSG_LOW, 4'd0, 1'b0, DUTY_OFF, 4'd0,
                                '0, '0, complete_flag_next);
            res_n = res_n + 2'd1;
            phase_next = PH_WAIT_HIGH;
          end
        end
        PH_SECOND: begin
          measure_timer_next = sat_inc(measure_timer);
          if (measure_timer_next >= cfg.measure_ticks) begin
            high_next  = lux;
            reading_wr = 1'b1;
            res[res_n] = mk_res(ACT_TX, MSG_HIGH, 4'd0, 1'b0, DUTY_OFF, 4'd0,
                                '0, '0, complete_flag_next);
            res_n = res_n + 2'd1;
            phase_next = PH_WAIT_DONE;
          end
        end
        PH_WAIT_HIGH: begin
          if (ack_count == need) begin
            res[res_n] = mk_res(ACT_DUTY, MSG_REQUEST, 4'd0, 1'b0, DUTY_HIGH, 4'd0,
                                '0, '0, complete_flag_next);
            res_n = res_n + 2'd1;
            measure_timer_next = '0;
            ack_count_next     = 5'd0;
            phase_next         = PH_SECOND;
          end
        end
        PH_WAIT_DONE: begin
          if (ack_count == need) begin
            res[res_n] = mk_res(ACT_TX, MSG_DONE, 4'd0, 1'b0, DUTY_OFF, 4'd0,
                                '0, '0, complete_flag_next);
            res_n = res_n + 2'd1;
            low_next   = '0;
            high_next  = '0;
            reading_wr = 1'b1;
            res[res_n] = mk_res(ACT_DUTY, MSG_REQUEST, 4'd0, 1'b0, DUTY_OFF, 4'd0,
                                '0, '0, complete_flag_next);
            res_n = res_n + 2'd1;
            if (turn_index < n_eff) begin
              turn_index_next = turn_index + 5'd1;
            end
            if (turn_index_next >= n_eff) begin
              complete_flag_next = 1'b1;
              phase_next         = PH_FINISH;
            end else begin
              phase_next = PH_IDLE;
            end
            res[res_n] = mk_res(ACT_GAIN, MSG_REQUEST, 4'd0, 1'b0, DUTY_OFF,
                                turn_index[3:0], gain_value, offs, complete_flag_next);
            res_n = res_n + 2'd1;
          end
        end
        PH_FINISH: begin
          res[res_n] = mk_res(ACT_TX, MSG_ALL_DONE, 4'd0, 1'b0, DUTY_OFF, 4'd0,
                              '0, '0, complete_flag_next);
          res_n = res_n + 2'd1;
          phase_next = PH_IDLE;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  // State update on commit
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      turn_index    <= '0;
      ack_count     <= '0;
      low_reading   <= '0;
      high_reading  <= '0;
      measure_timer <= '0;
      resend_timer  <= '0;
      complete_flag <= 1'b0;
    end else if (commit) begin
      phase         <= phase_next;
      turn_index    <= turn_index_next;
      ack_count     <= ack_count_next;
      low_reading   <= low_next;
      high_reading  <= high_next;
      measure_timer <= measure_timer_next;
      resend_timer  <= resend_timer_next;
      complete_flag <= complete_flag_next;
    end
  end

endmodule
`default_nettype wire

### rtl/tbgc_resbuf.sv
`default_nettype none
module tbgc_resbuf import tbgc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        load,
  input  wire res_t        res [3],
  input  wire logic [1:0]  res_n,
  output logic             can_load,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [79:0]      m_tdata,
  output logic             m_tlast
);

  res_t       slot [3];
  logic [1:0] cnt;
  logic       pop;

  assign pop      = m_tvalid && m_tready;
  assign can_load = (cnt == 2'd0) || (cnt == 2'd1 && m_tready);
  assign m_tvalid = (cnt != 2'd0);
  assign m_tdata  = {1'b0, slot[0]};
  assign m_tlast  = (cnt == 2'd1);

  // Result count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= res_n;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  // Result slots, head at slot 0
  always_ff @(posedge clk) begin
    if (load) begin
      slot[0] <= res[0];
      slot[1] <= res[1];
      slot[2] <= res[2];
    end else if (pop) begin
      slot[0] <= slot[1];
      slot[1] <= slot[2];
    end
  end

endmodule
`default_nettype wire

### rtl/turn_based_gain_calibration_sequencer.sv
`default_nettype none
// Channel  | Dir | Signals                      | Content
// s_       | in  | tvalid tready tdata tuser    | one tick or received frame
// m_       | out | tvalid tready tdata tlast     | up to three results per item
// cfg_     | in  | we index data                | configuration registers 0..4
//
// An item sits in the input register and is processed when the result buffer is
// empty or draining its last result; an item with k results occupies the output
// until all k are taken, so the next item waits for the buffer to drain. A
// change of the low or high reading holds the next item while the two-stage
// gain unit settles. Reset is synchronous and clears control state at once; no
// clearing pass. Either side may stall.
module turn_based_gain_calibration_sequencer import tbgc_pkg::*; #(
  parameter int LUX_BITS = 24
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [39:0]           s_tdata,   // rx_type, rx_sender, rx_data, lux_sample
  input  wire logic                  s_tuser,   // mode
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [79:0]                m_tdata,   // action, tx_type, tx_data, tx_length,
                                                // duty, gain_slot, gain_value,
                                                // offset_value, all_done, zero pad
  output logic                       m_tlast,   // last
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DAT_W-1:0]  cfg_data
);

  localparam int RW = (LUX_BITS < LUX_W) ? LUX_BITS : LUX_W;

  cfg_t                     cfg;
  item_t                    in_item;
  logic                     in_valid;
  logic                     commit;
  logic                     can_load;
  logic [1:0]               gain_wait;
  res_t                     res [3];
  logic [1:0]               res_n;
  logic [RW-1:0]            low_reading;
  logic [RW-1:0]            high_reading;
  logic                     reading_wr;
  logic signed [GAIN_W-1:0] gain_value;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_node_id   <= 4'd0;
      cfg.node_count    <= 5'd1;
      cfg.node_order    <= '0;
      cfg.measure_ticks <= TIMER_W'(1000);
      cfg.resend_ticks  <= TIMER_W'(100);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OWN_ID:        cfg.own_node_id   <= cfg_data[3:0];
        REG_NODE_COUNT:    cfg.node_count    <= cfg_data[4:0];
        REG_NODE_ORDER:    cfg.node_order    <= cfg_data[ORDER_W-1:0];
        REG_MEASURE_TICKS: cfg.measure_ticks <= cfg_data[TIMER_W-1:0];
        REG_RESEND_TICKS:  cfg.resend_ticks  <= cfg_data[TIMER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register
  assign commit   = in_valid && can_load && (gain_wait == 2'd0);
  assign s_tready = !in_valid || commit;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (commit) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item <= {s_tdata, s_tuser};
    end
  end

  // Hold items while the gain pipeline catches up with new readings
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_wait <= 2'd2;
    end else if (commit && reading_wr) begin
      gain_wait <= 2'd2;
    end else if (gain_wait != 2'd0) begin
      gain_wait <= gain_wait - 2'd1;
    end
  end

  tbgc_core #(.RW(RW)) u_core (
    .clk          (clk),
    .rst          (rst),
    .commit       (commit),
    .item         (in_item),
    .cfg          (cfg),
    .gain_value   (gain_value),
    .res          (res),
    .res_n        (res_n),
    .low_reading  (low_reading),
    .high_reading (high_reading),
    .reading_wr   (reading_wr)
  );

  tbgc_gain #(.RW(RW)) u_gain (
    .clk          (clk),
    .low_reading  (low_reading),
    .high_reading (high_reading),
    .gain_value   (gain_value)
  );

  tbgc_resbuf u_resbuf (
    .clk      (clk),
    .rst      (rst),
    .load     (commit),
    .res      (res),
    .res_n    (res_n),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
`default_nettype wire

### dv/turn_based_gain_calibration_sequencer_tb.sv
`default_nettype none
module turn_based_gain_calibration_sequencer_tb;
  import tbgc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 12;
  localparam int CHOKE_CYCLES = 60;
  localparam int MAX_REPORTS = 30;

  // Sequencer phases as tracked by the predictor
  typedef enum logic [2:0] {
    SQ_IDLE, SQ_WAIT_ACK, SQ_FIRST, SQ_WAIT_HIGH, SQ_SECOND, SQ_WAIT_DONE, SQ_FINISH
  } seq_phase_t;

  // One expected result plus its end-of-item mark
  typedef struct packed {
    logic last;
    res_t r;
  } seq_result_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [39:0]          s_tdata = '0;   // rx_type, rx_sender, rx_data, lux_sample
  logic                 s_tuser = 1'b0; // mode
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [79:0]          m_tdata;        // action, tx_type, tx_data, tx_length, duty,
                                        // gain_slot, gain_value, offset_value, all_done, pad
  logic                 m_tlast;        // last
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  turn_based_gain_calibration_sequencer DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Predictor copy of the configuration
  logic [3:0]  cf_id = 4'd0;
  logic [4:0]  cf_count = 5'd1;
  logic [63:0] cf_order = '0;
  logic [31:0] cf_meas = 32'd1000;
  logic [31:0] cf_resend = 32'd100;

  // Predictor copy of the sequencer state
  seq_phase_t  ph = SQ_IDLE;
  logic [4:0]  turn = '0;
  logic [4:0]  acks = '0;
  logic [23:0] lo_rd = '0;
  logic [23:0] hi_rd = '0;
  logic [31:0] meas_t = '0;
  logic [31:0] resend_t = '0;
  logic        done_flag = 1'b0;

  seq_result_t step_out[$];
  seq_result_t due_results[$];
  item_t       bus_events[$];

  int events_queued = 0;
  int events_taken = 0;
  int errors = 0;
  int cycles = 0;
  bit calm = 1'b0;
  int choke_req = 0;
  int choke_seen = 0;
  int choke_left = 0;
  int sink_gap = 0;
  int src_gap = 0;
  item_t on_bus;
  res_t got;
  seq_result_t want;

  function automatic void add_action(act_t a, msg_t t, logic [3:0] d, logic len,
                                     logic [11:0] duty, logic [3:0] slot,
                                     logic signed [GAIN_W-1:0] g,
                                     logic signed [GAIN_W-1:0] o);
    seq_result_t x;
    if (step_out.size() >= 3) return;
    x.last = 1'b0;
    x.r.action = a;
    x.r.tx_type = t;
    x.r.tx_data = d;
    x.r.tx_length = len;
    x.r.duty = duty;
    x.r.gain_slot = slot;
    x.r.gain_value = g;
    x.r.offset_value = o;
    x.r.all_done = done_flag;
    step_out.push_back(x);
  endfunction

  function automatic void send_frame(msg_t t);
    add_action(ACT_TX, t, 4'd0, 1'b0, DUTY_OFF, 4'd0, '0, '0);
  endfunction

  function automatic void send_ack(logic [3:0] target);
    add_action(ACT_TX, MSG_ACK, target, 1'b1, DUTY_OFF, 4'd0, '0, '0);
  endfunction

  function automatic void set_lamp(logic [11:0] duty);
    add_action(ACT_DUTY, MSG_REQUEST, 4'd0, 1'b0, duty, 4'd0, '0, '0);
  endfunction

  // Node count clamped to 1..16
  function automatic logic [4:0] live_nodes();
    if (cf_count == 5'd0) return 5'd1;
    if (cf_count > MAX_NODES) return MAX_NODES;
    return cf_count;
  endfunction

  // (high - low) * 5 / 3, truncated toward zero
  function automatic logic signed [GAIN_W-1:0] gain_now();
    longint h;
    longint l;
    longint d;
    h = longint'(hi_rd);
    l = longint'(lo_rd);
    d = ((h - l) * 5) / 3;
    return d[GAIN_W-1:0];
  endfunction

  function automatic logic [31:0] sat_up(logic [31:0] t);
    return (t == TIMER_MAX) ? t : t + 32'd1;
  endfunction

  // Returns 1 once the last turn has ended
  function automatic bit advance_turn();
    logic [4:0] n;
    n = live_nodes();
    if (turn < n) turn = turn + 5'd1;
    return turn >= n;
  endfunction

  function automatic void frame_update(item_t it);
    logic signed [GAIN_W-1:0] g;
    logic [3:0] slot;
    if (it.rx_type > {1'b0, MSG_ALL_DONE}) return;  // unknown frame types are dropped
    case (msg_t'(it.rx_type[2:0]))
      MSG_REQUEST: send_ack(it.rx_sender);
      MSG_ACK: begin
        if (it.rx_data == {4'd0, cf_id} && acks < ACK_MAX) acks = acks + 5'd1;
      end
      MSG_LOW: begin
        lo_rd = it.lux_sample;
        send_ack(it.rx_sender);
      end
      MSG_HIGH: begin
        hi_rd = it.lux_sample;
        send_ack(it.rx_sender);
      end
      MSG_DONE: begin
        g = gain_now();
        slot = turn[3:0];
        lo_rd = '0;
        hi_rd = '0;
        ph = SQ_IDLE;
        if (advance_turn()) begin
          done_flag = 1'b1;
          add_action(ACT_GAIN, MSG_REQUEST, 4'd0, 1'b0, DUTY_OFF, slot, g, '0);
          send_frame(MSG_ALL_DONE);
        end else begin
          add_action(ACT_GAIN, MSG_REQUEST, 4'd0, 1'b0, DUTY_OFF, slot, g, '0);
        end
      end
      MSG_ALL_DONE: done_flag = 1'b1;
      default: ;
    endcase
  endfunction

  function automatic void tick_update(item_t it);
    logic [4:0] n;
    logic [4:0] need;
    logic signed [GAIN_W-1:0] g;
    logic signed [GAIN_W-1:0] o;
    logic [3:0] slot;
    n = live_nodes();
    need = n - 5'd1;
    case (ph)
      SQ_IDLE: begin
        if (turn < n && cf_order[4*turn +: 4] == cf_id) begin
          send_frame(MSG_REQUEST);
          acks = '0;
          resend_t = '0;
          ph = SQ_WAIT_ACK;
        end
      end
      SQ_WAIT_ACK: begin
        resend_t = sat_up(resend_t);
        if (resend_t >= cf_resend) begin
          send_frame(MSG_REQUEST);
          acks = '0;
          resend_t = '0;
        end
        if (acks == need) begin
          set_lamp(DUTY_LOW);
          meas_t = '0;
          acks = '0;
          ph = SQ_FIRST;
        end
      end
      SQ_FIRST, SQ_SECOND: begin
        meas_t = sat_up(meas_t);
        if (meas_t >= cf_meas) begin
          if (ph == SQ_FIRST) begin
            lo_rd = it.lux_sample;
            send_frame(MSG_LOW);
            ph = SQ_WAIT_HIGH;
          end else begin
            hi_rd = it.lux_sample;
            send_frame(MSG_HIGH);
            ph = SQ_WAIT_DONE;
          end
        end
      end
      SQ_WAIT_HIGH: begin
        if (acks == need) begin
          set_lamp(DUTY_HIGH);
          meas_t = '0;
          acks = '0;
          ph = SQ_SECOND;
        end
      end
      SQ_WAIT_DONE: begin
        if (acks == need) begin
          g = gain_now();
          o = $signed({2'b00, hi_rd}) - g;
          slot = turn[3:0];
          send_frame(MSG_DONE);
          lo_rd = '0;
          hi_rd = '0;
          set_lamp(DUTY_OFF);
          if (advance_turn()) begin
            done_flag = 1'b1;
            ph = SQ_FINISH;
          end else begin
            ph = SQ_IDLE;
          end
          add_action(ACT_GAIN, MSG_REQUEST, 4'd0, 1'b0, DUTY_OFF, slot, g, o);
        end
      end
      SQ_FINISH: begin
        send_frame(MSG_ALL_DONE);
        ph = SQ_IDLE;
      end
      default: ph = SQ_IDLE;
    endcase
  endfunction

  // Work out the results of one accepted item and queue them
  function automatic void sequencer_step(item_t it);
    step_out.delete();
    if (it.mode) frame_update(it);
    else tick_update(it);
    if (step_out.size() > 0) step_out[step_out.size()-1].last = 1'b1;
    foreach (step_out[i]) due_results.push_back(step_out[i]);
  endfunction

  function automatic void note_mismatch(string what, logic [63:0] exp_v, logic [63:0] act_v);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, act_v);
  endfunction

  function automatic void check_field(string what, logic [63:0] exp_v, logic [63:0] act_v);
    if (act_v !== exp_v) note_mismatch(what, exp_v, act_v);
  endfunction

  // Random bus traffic, weighted toward ticks, ACKs and the known frame types
  function automatic item_t make_event();
    item_t it;
    int pick;
    it.mode = 1'b1;
    it.rx_type = 4'($urandom_range(0, 15));
    it.rx_sender = 4'($urandom_range(0, 15));
    it.rx_data = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 5))
      0: it.lux_sample = 24'hFFFFFF;
      1: it.lux_sample = 24'h000000;
      default: it.lux_sample = 24'($urandom);
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      it.mode = 1'b0;
    end else if (pick < 60) begin
      it.rx_type = {1'b0, MSG_ACK};
      if ($urandom_range(0, 7) != 0) it.rx_data = {4'd0, cf_id};
    end else if (pick < 68) begin
      it.rx_type = {1'b0, MSG_REQUEST};
    end else if (pick < 76) begin
      it.rx_type = {1'b0, MSG_LOW};
    end else if (pick < 84) begin
      it.rx_type = {1'b0, MSG_HIGH};
    end else if (pick < 89) begin
      it.rx_type = {1'b0, MSG_DONE};
    end else if (pick < 92) begin
      it.rx_type = {1'b0, MSG_ALL_DONE};
    end
    return it;
  endfunction

  // Turn order with about half the slots owned by this node
  function automatic logic [63:0] order_for(logic [3:0] id);
    logic [63:0] o;
    for (int k = 0; k < 16; k++)
      o[4*k +: 4] = ($urandom_range(0, 1) != 0) ? id : 4'($urandom_range(0, 15));
    return o;
  endfunction

  task automatic add_event(logic mode, msg_t typ, logic [3:0] snd, logic [7:0] data,
                           logic [23:0] lux);
    item_t it;
    it.mode = mode;
    it.rx_type = {1'b0, typ};
    it.rx_sender = snd;
    it.rx_data = data;
    it.lux_sample = lux;
    bus_events.push_back(it);
    events_queued++;
  endtask

  task automatic write_reg(reg_idx_t idx, logic [63:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    case (idx)
      REG_OWN_ID:        cf_id = v[3:0];
      REG_NODE_COUNT:    cf_count = v[4:0];
      REG_NODE_ORDER:    cf_order = v;
      REG_MEASURE_TICKS: cf_meas = v[31:0];
      REG_RESEND_TICKS:  cf_resend = v[31:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(logic [3:0] id, logic [4:0] count, logic [63:0] order,
                           logic [31:0] meas, logic [31:0] resend);
    write_reg(REG_OWN_ID, {60'd0, id});
    write_reg(REG_NODE_COUNT, {59'd0, count});
    write_reg(REG_NODE_ORDER, order);
    write_reg(REG_MEASURE_TICKS, {32'd0, meas});
    write_reg(REG_RESEND_TICKS, {32'd0, resend});
  endtask

  // Hold the sender until every item is taken and every result has come
  task automatic drain();
    while (events_taken != events_queued || due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_items(int count);
    repeat (count) begin
      bus_events.push_back(make_event());
      events_queued++;
    end
  endtask

  function automatic logic [4:0] count_ahead(int extra);
    int t;
    t = turn + extra;
    return (t > 16) ? 5'd16 : 5'(t);
  endfunction

  // Input driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        sequencer_step(on_bus);
        events_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (bus_events.size() > 0) begin
          on_bus = bus_events.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= on_bus[40:1];
          s_tuser <= on_bus.mode;
          if (!calm && $urandom_range(0, 4) == 0) src_gap = $urandom_range(1, 4);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result-side ready: random bursts plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (choke_req != choke_seen) begin
      choke_seen = choke_req;
      choke_left = CHOKE_CYCLES;
      m_tready <= 1'b0;
    end else if (choke_left > 0) begin
      choke_left--;
      m_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      m_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      sink_gap = $urandom_range(0, 3);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[78:0];
      if (due_results.size() == 0) begin
        note_mismatch("unexpected result", '0, m_tdata[63:0]);
      end else begin
        want = due_results.pop_front();
        check_field("action", 64'(want.r.action), 64'(got.action));
        check_field("tx_type", 64'(want.r.tx_type), 64'(got.tx_type));
        check_field("tx_data", 64'(want.r.tx_data), 64'(got.tx_data));
        check_field("tx_length", 64'(want.r.tx_length), 64'(got.tx_length));
        check_field("duty", 64'(want.r.duty), 64'(got.duty));
        check_field("gain_slot", 64'(want.r.gain_slot), 64'(got.gain_slot));
        check_field("gain_value", 64'(want.r.gain_value), 64'(got.gain_value));
        check_field("offset_value", 64'(want.r.offset_value), 64'(got.offset_value));
        check_field("all_done", 64'(want.r.all_done), 64'(got.all_done));
        check_field("last", 64'(want.last), 64'(m_tlast));
        check_field("pad bit", 64'd0, 64'(m_tdata[79]));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic [3:0] id;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: own turn first (slot 0 = 5), then node 2's turn, slot 2 = node 9
    configure(4'd5, 5'd3, 64'h0000_0000_0000_0925, 32'd2, 32'd3);
    bus_events.push_back('{lux_sample: 24'h000000, rx_data: 8'hFF, rx_sender: 4'd0,
                           rx_type: 4'hF, mode: 1'b1});
    events_queued++;
    add_event(1'b1, MSG_REQUEST, 4'd15, 8'd0, 24'h123456);
    add_event(1'b0, MSG_REQUEST, 4'd0, 8'd0, 24'h0);      // request the turn
    add_event(1'b0, MSG_REQUEST, 4'd0, 8'd0, 24'h0);
    add_event(1'b0, MSG_REQUEST, 4'd0, 8'd0, 24'h0);
    add_event(1'b0, MSG_REQUEST, 4'd0, 8'd0, 24'h0);      // resend interval hit
    add_event(1'b1, MSG_ACK, 4'd2, 8'd5, 24'h0);
    add_event(1'b1, MSG_ACK, 4'd9, 8'h85, 24'h0);          // not addressed to us
    add_event(1'b1, MSG_ACK, 4'd9, 8'd5, 24'h0);
    add_event(1'b0, MSG_REQUEST, 4'd0, 8'd0, 24'h0);      // low duty
    add_event(1'b0, MSG_REQUEST, 4'd0, 8'd0, 24'h0);
    add_event(1'b0, MSG_REQUEST, 4'd0, 8'd0, 24'hFFFFFF); // low reading
    add_event(1'b1, MSG_ACK, 4'd2, 8'd5, 24'h0);
    add_event(1'b1, MSG_ACK, 4'd9, 8'd5, 24'h0);
    add_event(1'b0, MSG_REQUEST, 4'd0, 8'd0, 24'h0);      // high duty
    add_event(1'b0, MSG_REQUEST, 4'd0, 8'd0, 24'h0);
    add_event(1'b0, MSG_REQUEST, 4'd0, 8'd0, 24'h0);      // high reading
    add_event(1'b1, MSG_ACK, 4'd2, 8'd5, 24'h0);
    add_event(1'b1, MSG_ACK, 4'd9, 8'd5, 24'h0);
    add_event(1'b0, MSG_REQUEST, 4'd0, 8'd0, 24'h0);      // most negative gain
    add_event(1'b1, MSG_LOW, 4'd2, 8'd0, 24'h000000);
    add_event(1'b1, MSG_HIGH, 4'd2, 8'd0, 24'hFFFFFF);
    add_event(1'b1, MSG_DONE, 4'd2, 8'd0, 24'h0);         // most positive gain
    add_event(1'b0, MSG_REQUEST, 4'd0, 8'd0, 24'h0);      // slot owned by node 9
    add_event(1'b1, MSG_ALL_DONE, 4'd9, 8'd0, 24'h0);
    drain();

    // Top id, immediate sampling, resend never due; long result-side hold-off
    configure(4'hF, count_ahead(3), order_for(4'hF), 32'd0, 32'hFFFF_FFFF);
    choke_req <= choke_req + 1;
    random_items(21);
    drain();

    // Node count of zero acts as one: no ACKs needed; resend on every tick
    configure(4'd0, 5'd0, 64'd0, 32'd1, 32'd0);
    random_items(21);
    drain();

    // Count above the node limit, all-ones order
    id = 4'($urandom_range(0, 15));
    configure(id, 5'd31, 64'hFFFF_FFFF_FFFF_FFFF, 32'd3, 32'd2);
    random_items(21);
    drain();

    // Measurement never completes
    id = 4'($urandom_range(0, 15));
    configure(id, count_ahead(2), order_for(id), 32'hFFFF_FFFF, 32'd5);
    random_items(21);
    drain();

    // Last part without idling on either side
    calm = 1'b1;
    id = 4'($urandom_range(0, 15));
    configure(id, 5'd16, order_for(id), 32'd2, 32'd50);
    random_items(21);
    drain();

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
